>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define SET_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/set_pkg.sv
`default_nettype none

package set_pkg;

   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 128;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int SIZE_W   = 8;
   localparam int PIX_W    = 8;
   localparam int THR_W    = 11;
   localparam int THR2_W   = 2 * THR_W;
   localparam int GRAD_W   = 10;
   localparam int SQ_W     = 2 * GRAD_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(100);
   localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(120);
   localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(120);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);

   typedef enum logic [1:0] {
      REG_EDGE_THRESHOLD,
      REG_IMAGE_COLS,
      REG_IMAGE_ROWS
   } reg_index_type;

   // Window pixels, indexed [row][col]; row 0 is the oldest line.
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic [SIZE_W-1:0] cols;
      logic [SIZE_W-1:0] rows;
   } size_cfg_type;

   typedef struct packed {
      win_type          win;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } queue_entry_type;

endpackage

`default_nettype wire

>>> hw/rtl/set_ram.sv
`default_nettype none

module set_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/set_queue.sv
`default_nettype none
`include "assert_macros.svh"

module set_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire set_pkg::queue_entry_type push_entry,
   input  wire logic                     pop,
   output set_pkg::queue_entry_type      head,
   output logic                          empty,
   output logic [set_pkg::QCNT_W-1:0]    count
);

   set_pkg::queue_entry_type          entries_ff [set_pkg::QUEUE_DEPTH];
   logic [set_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [set_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [set_pkg::QCNT_W-1:0]        count_ff, count_in;

   function automatic logic [set_pkg::QPTR_W-1:0] next_ptr(
      input logic [set_pkg::QPTR_W-1:0] ptr
   );
      logic [set_pkg::QPTR_W-1:0] res;
      if (ptr == set_pkg::QPTR_W'(set_pkg::QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   `SET_ASSERT(a_no_overflow, clock, reset,
      !(push && !pop && count_ff == set_pkg::QCNT_W'(set_pkg::QUEUE_DEPTH)))
   `SET_ASSERT(a_no_underflow, clock, reset, !(pop && count_ff == '0))

endmodule

`default_nettype wire

>>> hw/rtl/set_front.sv
`default_nettype none
`include "assert_macros.svh"

module set_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [set_pkg::PIX_W-1:0] req_tdata,
   input  wire logic                      req_tuser,
   input  wire set_pkg::size_cfg_type     cfg,
   input  wire logic [set_pkg::QCNT_W-1:0] q_count,
   output logic                           q_push,
   output set_pkg::queue_entry_type       q_entry
);

   localparam int COL_W  = set_pkg::COL_W;
   localparam int ROW_W  = set_pkg::ROW_W;
   localparam int SIZE_W = set_pkg::SIZE_W;
   localparam int PIX_W  = set_pkg::PIX_W;

   logic accept;

   // position counters
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row0, row_cur;
   logic [COL_W-1:0]  col0, col_cur;
   logic              wrap_col;
   logic [SIZE_W-1:0] row_step, col_next, row_next;

   // line-store stage
   logic              s1_valid_ff;
   logic              s1_produce_ff, s1_produce_in;
   logic              s1_last_ff, s1_last_in;
   logic              s1_hazard_ff, s1_hazard_in;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [PIX_W-1:0]  up_rd, mid_rd, up_eff, mid_eff;
   logic [PIX_W-1:0]  fwd_up_ff, fwd_mid_ff;
   set_pkg::win_type  win_ff, win_in;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      row0     = req_tuser ? '0 : row_ff;
      col0     = req_tuser ? '0 : col_ff;
      wrap_col = ({1'b0, col0} >= cfg.cols);
      col_cur  = wrap_col ? '0 : col0;
      row_step = wrap_col ? ({1'b0, row0} + 1'b1) : {1'b0, row0};
      row_cur  = (row_step >= cfg.rows) ? '0 : row_step[ROW_W-1:0];

      col_next = {1'b0, col_cur} + 1'b1;
      row_next = {1'b0, row_cur} + 1'b1;
      if (col_next >= cfg.cols) begin
         col_in = '0;
         row_in = (row_next >= cfg.rows) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[COL_W-1:0];
         row_in = row_cur;
      end

      s1_produce_in = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      s1_last_in    = ({1'b0, row_cur} == cfg.rows - 1'b1)
                      && ({1'b0, col_cur} == cfg.cols - 1'b1);
      // the entry written this cycle is read back stale by the RAM
      s1_hazard_in  = s1_valid_ff && (s1_col_ff == col_cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= req_tdata;
         s1_row_ff     <= row_cur;
         s1_col_ff     <= col_cur;
         s1_produce_ff <= s1_produce_in;
         s1_last_ff    <= s1_last_in;
         s1_hazard_ff  <= s1_hazard_in;
      end
      if (s1_valid_ff) begin
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= s1_pix_ff;
      end
   end

   set_ram #(
      .WIDTH (PIX_W),
      .DEPTH (set_pkg::MAX_COLS)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_eff),
      .rd_addr (col_cur),
      .rd_data (up_rd)
   );

   set_ram #(
      .WIDTH (PIX_W),
      .DEPTH (set_pkg::MAX_COLS)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (col_cur),
      .rd_data (mid_rd)
   );

   always_comb begin
      up_eff  = s1_hazard_ff ? fwd_up_ff  : up_rd;
      mid_eff = s1_hazard_ff ? fwd_mid_ff : mid_rd;
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = up_eff;
      win_in[1][2] = mid_eff;
      win_in[2][2] = s1_pix_ff;
   end

   assign q_push        = s1_valid_ff && s1_produce_ff;
   assign q_entry.win   = win_in;
   assign q_entry.row   = s1_row_ff - 1'b1;
   assign q_entry.col   = s1_col_ff - 1'b1;
   assign q_entry.last  = s1_last_ff;

   // reserve a queue slot for the item still in the line-store stage
   assign req_tready = ({1'b0, q_count} + (set_pkg::QCNT_W + 1)'(q_push))
                       < (set_pkg::QCNT_W + 1)'(set_pkg::QUEUE_DEPTH);

   `SET_ASSERT_NEXT(a_accept_to_s1, clock, reset, accept, s1_valid_ff)
   `SET_ASSERT(a_push_from_interior, clock, reset,
      !q_push || (s1_row_ff >= ROW_W'(2) && s1_col_ff >= COL_W'(2)))

endmodule

`default_nettype wire

>>> hw/rtl/set_back.sv
`default_nettype none
`include "assert_macros.svh"

module set_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [set_pkg::THR2_W-1:0] thr2,
   input  wire logic                       q_empty,
   input  wire set_pkg::queue_entry_type   q_head,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int GRAD_W = set_pkg::GRAD_W;
   localparam int SQ_W   = set_pkg::SQ_W;
   localparam int PIX_W  = set_pkg::PIX_W;
   localparam int ROW_W  = set_pkg::ROW_W;
   localparam int COL_W  = set_pkg::COL_W;

   logic              adv;
   logic [GRAD_W-1:0] right, left, top, bot, ax_in, ay_in;

   logic              b1_valid_ff, b2_valid_ff, out_valid_ff;
   logic [GRAD_W-1:0] ax_ff, ay_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [SQ_W:0]     mag2;
   logic              is_edge_in;

   logic [ROW_W-1:0]  b1_row_ff, b2_row_ff, out_row_ff;
   logic [COL_W-1:0]  b1_col_ff, b2_col_ff, out_col_ff;
   logic [PIX_W-1:0]  b1_gray_ff, b2_gray_ff, out_gray_ff;
   logic              b1_last_ff, b2_last_ff, out_last_ff;
   logic              out_edge_ff;

   function automatic logic [GRAD_W-1:0] tap_sum(
      input logic [PIX_W-1:0] a,
      input logic [PIX_W-1:0] b,
      input logic [PIX_W-1:0] c
   );
      return GRAD_W'(a) + GRAD_W'({b, 1'b0}) + GRAD_W'(c);
   endfunction

   // advance the whole pipe whenever the output register frees up
   assign adv   = !out_valid_ff || rsp_tready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      right = tap_sum(q_head.win[0][2], q_head.win[1][2], q_head.win[2][2]);
      left  = tap_sum(q_head.win[0][0], q_head.win[1][0], q_head.win[2][0]);
      top   = tap_sum(q_head.win[0][0], q_head.win[0][1], q_head.win[0][2]);
      bot   = tap_sum(q_head.win[2][0], q_head.win[2][1], q_head.win[2][2]);
      ax_in = (right > left) ? right - left : left - right;
      ay_in = (top > bot) ? top - bot : bot - top;
      mag2  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      is_edge_in = (set_pkg::THR2_W'(mag2) > thr2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= !q_empty;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff       <= ax_in;
         ay_ff       <= ay_in;
         b1_row_ff   <= q_head.row;
         b1_col_ff   <= q_head.col;
         b1_gray_ff  <= q_head.win[1][1];
         b1_last_ff  <= q_head.last;

         sqx_ff      <= ax_ff * ax_ff;
         sqy_ff      <= ay_ff * ay_ff;
         b2_row_ff   <= b1_row_ff;
         b2_col_ff   <= b1_col_ff;
         b2_gray_ff  <= b1_gray_ff;
         b2_last_ff  <= b1_last_ff;

         out_edge_ff <= is_edge_in;
         out_row_ff  <= b2_row_ff;
         out_col_ff  <= b2_col_ff;
         out_gray_ff <= b2_gray_ff;
         out_last_ff <= b2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_edge_ff, out_gray_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;

   `SET_ASSERT_NEXT(a_pop_fills_b1, clock, reset, q_pop, b1_valid_ff)
   `SET_ASSERT_NEXT(a_stall_holds_pipe, clock, reset,
      out_valid_ff && !rsp_tready && b2_valid_ff, b2_valid_ff && out_valid_ff)

endmodule

`default_nettype wire

>>> hw/rtl/sobel_edge_threshold.sv
`default_nettype none

// Sobel 3x3 edge detector for a raster stream of 8-bit grey pixels of up to
// 128 x 128 (size set through image_cols / image_rows, clamped to 3..128).
// One pixel is taken per clock while req_tready is high; a result is produced
// for every interior centre pixel through the line-store stage, the queue and
// the b1, b2 and output registers; the rate is set by the single-port-per-side
// line-store RAMs, which are read and written once per pixel. A four-entry queue
// separates the window front end from the gradient and compare pipeline, so a
// stalled result side holds the pixel input only once the queue, counting the
// entry still on its way in, is full. is_edge is set when
// gx*gx + gy*gy > edge_threshold^2. A frame begins at any pixel with
// frame_start set, or after the last pixel of the previous frame. Change the
// registers only while no pixel is in flight; the first two rows after reset
// or after a size change produce no trustworthy output until the line stores
// have been filled.

module sobel_edge_threshold (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] pixel_gray
   input  wire logic        req_tuser,   // [0] frame_start
   // edge result
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [6:0] center_row, [13:7] center_col, [21:14] center_gray, [22] is_edge
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,   // last_of_frame
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int THR_W  = set_pkg::THR_W;
   localparam int THR2_W = set_pkg::THR2_W;
   localparam int SIZE_W = set_pkg::SIZE_W;

   logic                      csr_write;
   set_pkg::reg_index_type    reg_index;
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic [THR2_W-1:0]         thr2_ff, thr2_in;
   logic [SIZE_W-1:0]         cols_ff, cols_in;
   logic [SIZE_W-1:0]         rows_ff, rows_in;
   set_pkg::size_cfg_type     size_cfg;

   logic                      q_push, q_pop, q_empty;
   set_pkg::queue_entry_type  q_entry, q_head;
   logic [set_pkg::QCNT_W-1:0] q_count;

   function automatic logic [SIZE_W-1:0] clamp_size(
      input logic [SIZE_W-1:0] v,
      input logic [SIZE_W-1:0] hi
   );
      logic [SIZE_W-1:0] res;
      if (v < set_pkg::SIZE_MIN) begin
         res = set_pkg::SIZE_MIN;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = set_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      thr_in  = thr_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write) begin
         unique case (reg_index)
            set_pkg::REG_EDGE_THRESHOLD: thr_in  = csr_pwdata[THR_W-1:0];
            set_pkg::REG_IMAGE_COLS:     cols_in = csr_pwdata[SIZE_W-1:0];
            set_pkg::REG_IMAGE_ROWS:     rows_in = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         set_pkg::REG_EDGE_THRESHOLD: csr_prdata = 32'(thr_ff);
         set_pkg::REG_IMAGE_COLS:     csr_prdata = 32'(cols_ff);
         set_pkg::REG_IMAGE_ROWS:     csr_prdata = 32'(rows_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // square the threshold into a register that follows the threshold register
   assign thr2_in = THR2_W'(thr_ff) * THR2_W'(thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= set_pkg::THR_RESET;
         thr2_ff <= THR2_W'(set_pkg::THR_RESET) * THR2_W'(set_pkg::THR_RESET);
         cols_ff <= set_pkg::COLS_RESET;
         rows_ff <= set_pkg::ROWS_RESET;
      end else begin
         thr_ff  <= thr_in;
         thr2_ff <= thr2_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   assign size_cfg.cols = clamp_size(cols_ff, SIZE_W'(set_pkg::MAX_COLS));
   assign size_cfg.rows = clamp_size(rows_ff, SIZE_W'(set_pkg::MAX_ROWS));

   set_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (size_cfg),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   set_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .count      (q_count)
   );

   set_back u_back (
      .clock      (clock),
      .reset      (reset),
      .thr2       (thr2_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> tb/sv/sobel_edge_threshold_tb.sv
`default_nettype none

module sobel_edge_threshold_tb;

   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 30;
   localparam int SWAP_IDLE_AT  = 150;
   localparam int NO_IDLE_AT    = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [3:0] UNMAPPED_ADDR = 4'd12;

   localparam logic [7:0] CROSS_IMG [9] = '{8'h00, 8'hff, 8'h00,
                                            8'hff, 8'h00, 8'hff,
                                            8'h00, 8'hff, 8'h00};

   typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_STEP} pattern_kind_type;

   typedef struct {
      logic [6:0] row;
      logic [6:0] col;
      logic [7:0] gray;
      logic       is_edge;
      logic       frame_end;
   } edge_result_type;

   function automatic int unsigned dim_in_use(logic [7:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   class edge_scoreboard;
      logic [set_pkg::THR_W-1:0]  threshold;
      logic [set_pkg::SIZE_W-1:0] width_reg;
      logic [set_pkg::SIZE_W-1:0] height_reg;
      logic [set_pkg::PIX_W-1:0]  upper_line [set_pkg::MAX_COLS];
      logic [set_pkg::PIX_W-1:0]  middle_line [set_pkg::MAX_COLS];
      logic [set_pkg::PIX_W-1:0]  win [3][3];
      int unsigned                row_pos;
      int unsigned                col_pos;
      edge_result_type            expected_edges [$];
      int                         failures;

      function new();
         threshold  = set_pkg::THR_RESET;
         width_reg  = set_pkg::COLS_RESET;
         height_reg = set_pkg::ROWS_RESET;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         row_pos  = 0;
         col_pos  = 0;
         failures = 0;
      endfunction

      function void complain(string what);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%s", what);
      endfunction

      function void write_register(set_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            set_pkg::REG_EDGE_THRESHOLD: threshold  = value[set_pkg::THR_W-1:0];
            set_pkg::REG_IMAGE_COLS:     width_reg  = value[set_pkg::SIZE_W-1:0];
            set_pkg::REG_IMAGE_ROWS:     height_reg = value[set_pkg::SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(set_pkg::reg_index_type idx);
         case (idx)
            set_pkg::REG_EDGE_THRESHOLD: return 32'(threshold);
            set_pkg::REG_IMAGE_COLS:     return 32'(width_reg);
            default:                     return 32'(height_reg);
         endcase
      endfunction

      function void check_register(set_pkg::reg_index_type idx, logic [31:0] got);
         if (got !== register_value(idx))
            complain($sformatf("register %s: expected %0d, got %0d",
                               idx.name(), register_value(idx), got));
      endfunction

      function void note_pixel(logic [7:0] pix, logic frame_start);
         int unsigned     cols, rows, r, c;
         int              right, left, top, bottom, ax, ay;
         edge_result_type res;
         cols = dim_in_use(width_reg, set_pkg::MAX_COLS);
         rows = dim_in_use(height_reg, set_pkg::MAX_ROWS);
         if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         // a counter left beyond a shrunk size wraps as at the end of a row
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= rows) row_pos = 0;
         r = row_pos;
         c = col_pos;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = upper_line[c];
         win[1][2] = middle_line[c];
         win[2][2] = pix;
         upper_line[c]  = middle_line[c];
         middle_line[c] = pix;
         if (r >= 2 && c >= 2) begin
            right  = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]);
            left   = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]);
            top    = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]);
            bottom = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]);
            ax = right > left ? right - left : left - right;
            ay = top > bottom ? top - bottom : bottom - top;
            res.row       = 7'(r - 1);
            res.col       = 7'(c - 1);
            res.gray      = win[1][1];
            res.is_edge   = (ax * ax + ay * ay) > int'(threshold) * int'(threshold);
            res.frame_end = (r == rows - 1) && (c == cols - 1);
            expected_edges = {expected_edges, res};
         end
         col_pos = c + 1;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= rows) row_pos = 0;
         end
      endfunction

      function void check_result(logic [23:0] data, logic tlast);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            complain($sformatf("unexpected result: row %0d col %0d gray %0d",
                               data[6:0], data[13:7], data[21:14]));
            return;
         end
         want = expected_edges.pop_front();
         if (data[6:0] !== want.row || data[13:7] !== want.col ||
             data[21:14] !== want.gray || data[22] !== want.is_edge ||
             tlast !== want.frame_end)
            complain($sformatf({"result mismatch: expected row %0d col %0d gray %0d",
                                " edge %0b last %0b, got row %0d col %0d gray %0d",
                                " edge %0b last %0b"},
                               want.row, want.col, want.gray, want.is_edge,
                               want.frame_end, data[6:0], data[13:7], data[21:14],
                               data[22], tlast));
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;    // [7:0] pixel_gray
   logic        req_tuser   = 1'b0;  // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [6:0] center_row, [13:7] center_col, [21:14] center_gray, [22] is_edge
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;           // last_of_frame
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned accepted      = 0;
   int unsigned quiet_cycles  = 0;
   edge_scoreboard sb;

   sobel_edge_threshold dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, sb.pending());
         $display("[sobel_edge_threshold] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idle_mode(int mode);
      case (mode)
         0: begin
            send_idle_pct = 14;
            recv_idle_pct = 71;
         end
         1: begin
            send_idle_pct = 71;
            recv_idle_pct = 14;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_pixel(logic [7:0] pix, logic frame_start);
      set_idle_mode(accepted < SWAP_IDLE_AT ? 0 : (accepted < NO_IDLE_AT ? 1 : 2));
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, frame_start);
      accepted++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // pixels near the border give no result, so allow for work still in flight
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (addr[3:2] <= set_pkg::REG_IMAGE_ROWS)
         sb.write_register(set_pkg::reg_index_type'(addr[3:2]), value);
   endtask

   task automatic csr_check(set_pkg::reg_index_type idx);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      sb.check_register(idx, got);
   endtask

   task automatic check_all_registers();
      csr_check(set_pkg::REG_EDGE_THRESHOLD);
      csr_check(set_pkg::REG_IMAGE_COLS);
      csr_check(set_pkg::REG_IMAGE_ROWS);
   endtask

   // upper bits of each word are junk and must be dropped by the block
   task automatic configure(logic [10:0] thr, logic [7:0] cols, logic [7:0] rows);
      logic [31:0] word;
      word = $urandom;
      word[set_pkg::THR_W-1:0] = thr;
      csr_write({set_pkg::REG_EDGE_THRESHOLD, 2'b00}, word);
      word = $urandom;
      word[set_pkg::SIZE_W-1:0] = cols;
      csr_write({set_pkg::REG_IMAGE_COLS, 2'b00}, word);
      word = $urandom;
      word[set_pkg::SIZE_W-1:0] = rows;
      csr_write({set_pkg::REG_IMAGE_ROWS, 2'b00}, word);
      check_all_registers();
   endtask

   task automatic send_run(pattern_kind_type kind, int unsigned cols, int unsigned count,
                           logic with_start, int pause_at);
      logic [7:0]  base, alt, pix;
      int unsigned r, c, split;
      base  = 8'($urandom);
      alt   = 8'($urandom);
      split = $urandom_range(cols + count / cols);
      for (int unsigned i = 0; i < count; i++) begin
         r = i / cols;
         c = i % cols;
         case (kind)
            PAT_FLAT: pix = base ^ 8'($urandom_range(3));
            PAT_RAMP: pix = 8'(base + c * (alt[2:0] + 1) * 9 + r * 3);
            PAT_STEP: pix = (r + c > split) ? alt : base;
            default:  pix = 8'($urandom);
         endcase
         if (int'(i) == pause_at) hold_until_drained();
         // a stray frame start now and then restarts the frame mid-way
         send_pixel(pix, (i == 0 && with_start) || $urandom_range(199) == 0);
      end
   endtask

   initial begin
      int unsigned      random_base, pick, noise, npix, eff_cols, eff_rows, frames;
      logic [10:0]      thr;
      logic [7:0]       cols_set, rows_set;
      pattern_kind_type kind;
      int               pause_at;

      sb = new();
      set_idle_mode(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_all_registers();

      // smallest frame, after an unmapped register write: cross, wrap into an all-white frame, bright top row
      configure(11'd0, 8'd3, 8'd3);
      csr_write(UNMAPPED_ADDR, $urandom);
      check_all_registers();
      foreach (CROSS_IMG[i]) send_pixel(CROSS_IMG[i], i == 0);
      for (int i = 0; i < 9; i++) send_pixel(8'hff, 1'b0);
      for (int i = 0; i < 9; i++) send_pixel(i < 3 ? 8'hff : 8'h00, i == 0);

      // sizes beyond range in both directions, full-width rows
      settle();
      configure(11'd1443, 8'd255, 8'd2);
      send_run(PAT_NOISE, set_pkg::MAX_COLS, set_pkg::MAX_COLS * 2 + 3, 1'b1, -1);
      settle();
      configure(11'd1, 8'd0, 8'd128);
      send_run(PAT_NOISE, 3, 18, 1'b1, 10);

      // shrink the frame while part way through it
      settle();
      configure(11'd150, 8'd12, 8'd9);
      send_run(PAT_STEP, 12, 32, 1'b1, -1);
      settle();
      configure(11'd150, 8'd6, 8'd9);
      send_run(PAT_RAMP, 6, 30, 1'b0, -1);
      settle();
      configure(11'd150, 8'd6, 8'd4);
      send_run(PAT_NOISE, 6, 24, 1'b0, -1);

      random_base = accepted;
      while (accepted - random_base < RANDOM_ITEMS) begin
         settle();
         pick = $urandom_range(9);
         if (pick == 0) thr = 11'd0;
         else if (pick == 1) thr = 11'd1443;
         else if (pick == 2) thr = 11'h7ff;
         else if (pick < 6) thr = 11'($urandom_range(1443));
         else thr = 11'($urandom_range(40, 400));
         cols_set = ($urandom_range(11) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(3, 18));
         rows_set = ($urandom_range(11) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(3, 7));
         configure(thr, cols_set, rows_set);
         eff_cols = dim_in_use(cols_set, set_pkg::MAX_COLS);
         eff_rows = dim_in_use(rows_set, set_pkg::MAX_ROWS);
         frames   = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            if (accepted - random_base >= RANDOM_ITEMS) break;
            kind     = pattern_kind_type'($urandom_range(3));
            noise    = $urandom_range(9);
            npix     = eff_cols * eff_rows;
            pause_at = (noise == 2) ? int'($urandom_range(npix - 1)) : -1;
            // abort a frame early, or run on into the next one with no start marker
            send_run(kind, eff_cols, (noise == 1) ? $urandom_range(1, npix - 1) : npix,
                     f == 0 || noise != 3, pause_at);
         end
      end

      settle();
      if (sb.failures == 0) $display("[sobel_edge_threshold] OK");
      else $display("[sobel_edge_threshold] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
